FILE: sv/three_lane_iir_filter_assert.svh
// ----------------------------------------------------------------------------
// three_lane_iir_filter_assert
// Assertion macros shared by the checker of the three-lane IIR filter.
// ----------------------------------------------------------------------------
`ifndef THREE_LANE_IIR_FILTER_ASSERT_SVH
`define THREE_LANE_IIR_FILTER_ASSERT_SVH

// check the consequent in the same cycle as the antecedent
`define TLIF_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// check the consequent in the cycle after the antecedent
`define TLIF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/tlif_pkg.sv
// ----------------------------------------------------------------------------
// tlif_pkg
// Constants, register codes and shared types of the three-lane IIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tlif_pkg;

   localparam int LANES           = 3;
   localparam int TAPS            = 5;
   localparam int HIST            = TAPS - 1;
   localparam int MAX_TAPS        = 5;

   localparam int SAMPLE_W        = 24;
   localparam int COEF_W          = 20;
   localparam int COEF_FRAC       = 16;
   localparam int COEFS_PER_GROUP = 3;
   localparam int GROUPS          = 3;
   localparam int GROUP_W         = COEFS_PER_GROUP * COEF_W;
   localparam int FB_SLOT0        = MAX_TAPS - 1;

   localparam int TAIL_W          = COEF_W + 3;
   localparam int PROD_W          = SAMPLE_W + COEF_W;
   localparam int TAIL_PROD_W     = SAMPLE_W + TAIL_W;
   localparam int ACC_W           = 48;
   localparam int QUO_W           = ACC_W - COEF_FRAC;

   localparam int CSR_DATA_W      = 64;
   localparam int CSR_ADDR_W      = 5;
   localparam int REG_IDX_W       = 2;
   localparam int REG_LSB         = 3;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_COEF_GROUP_0   = 2'd0,
      REG_COEF_GROUP_1   = 2'd1,
      REG_COEF_GROUP_2   = 2'd2,
      REG_PRIME_ON_FIRST = 2'd3
   } tlif_reg_type;

   typedef logic signed [SAMPLE_W-1:0] tlif_sample_type;

   typedef struct packed {
      logic [TAPS-1:0][COEF_W-1:0] ff;
      logic [HIST-1:0][COEF_W-1:0] fb;
      logic [TAIL_W-1:0]           fb_tail;
      logic                        prime;
   } tlif_coef_type;

   typedef struct packed {
      logic s1_load;
      logic s2_load;
      logic out_load;
      logic start;
   } tlif_ctl_type;

endpackage

`default_nettype wire

FILE: sv/tlif_lane.sv
// ----------------------------------------------------------------------------
// tlif_lane
// One filter lane: feed-forward products, their sum, and the feedback stage
// that rounds, saturates and updates the lane history.
// ----------------------------------------------------------------------------
`default_nettype none

module tlif_lane (
   input  logic                      clock,
   input  tlif_pkg::tlif_ctl_type    ctl,
   input  tlif_pkg::tlif_coef_type   coef,
   input  tlif_pkg::tlif_sample_type sample,
   output tlif_pkg::tlif_sample_type result,
   output logic                      sat
);
   import tlif_pkg::*;

   localparam tlif_sample_type S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam tlif_sample_type S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic signed [QUO_W-1:0] Q_HI = QUO_W'(S_MAX);
   localparam logic signed [QUO_W-1:0] Q_LO = QUO_W'(S_MIN);
   localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) << (COEF_FRAC - 1);

   tlif_sample_type               fill;
   tlif_sample_type               xe         [HIST];
   tlif_sample_type               xh_in      [HIST];
   tlif_sample_type               xh_ff      [HIST];
   logic signed [PROD_W-1:0]      prod       [TAPS];
   logic signed [PROD_W-1:0]      prod_ff    [TAPS];
   logic signed [TAIL_PROD_W-1:0] tail_prod;
   logic signed [TAIL_PROD_W-1:0] s1_tail_ff;
   logic                          s1_start_ff;
   tlif_sample_type               s1_fill_ff;

   logic signed [ACC_W-1:0]       ffsum_in;
   logic signed [ACC_W-1:0]       ffsum_ff;
   logic signed [TAIL_PROD_W-1:0] s2_tail_ff;
   logic                          s2_start_ff;
   tlif_sample_type               s2_fill_ff;

   tlif_sample_type               ye         [HIST];
   tlif_sample_type               yh_in      [HIST];
   tlif_sample_type               yh_ff      [HIST];
   logic signed [ACC_W-1:0]       fb_prev;
   logic signed [PROD_W-1:0]      fb1_prod;
   logic signed [ACC_W-1:0]       acc;
   logic signed [QUO_W-1:0]       quo;
   tlif_sample_type               fbp_opnd   [HIST-1];
   logic signed [PROD_W-1:0]      fbp_prod   [HIST-1];
   logic signed [ACC_W-1:0]       fbp_in;
   logic signed [ACC_W-1:0]       fbp_ff;
   tlif_sample_type               result_in;
   tlif_sample_type               result_ff;
   logic                          sat_in;
   logic                          sat_ff;

   // stage 1: rebuild history on start, form feed-forward products
   always_comb begin
      fill = coef.prime ? sample : '0;
      for (int k = 0; k < HIST; k++) xe[k] = ctl.start ? fill : xh_ff[k];
      prod[0] = $signed(coef.ff[0]) * sample;
      for (int k = 1; k < TAPS; k++) prod[k] = $signed(coef.ff[k]) * xe[k-1];
      tail_prod = $signed(coef.fb_tail) * fill;
      xh_in[0] = sample;
      for (int k = 1; k < HIST; k++) xh_in[k] = xe[k-1];
   end

   // stage 2: sum feed-forward products
   always_comb begin
      ffsum_in = '0;
      for (int k = 0; k < TAPS; k++) ffsum_in = ffsum_in + ACC_W'(prod_ff[k]);
   end

   // stage 3: close the feedback loop, round, saturate
   always_comb begin
      for (int k = 0; k < HIST; k++) ye[k] = s2_start_ff ? s2_fill_ff : yh_ff[k];
      fb_prev  = s2_start_ff ? ACC_W'(s2_tail_ff) : fbp_ff;
      fb1_prod = $signed(coef.fb[0]) * ye[0];
      acc      = ffsum_ff - fb_prev - ACC_W'(fb1_prod);
      quo      = QUO_W'((acc + RND) >>> COEF_FRAC);
      sat_in   = 1'b0;
      if (quo > Q_HI) begin
         result_in = S_MAX;
         sat_in    = 1'b1;
      end else if (quo < Q_LO) begin
         result_in = S_MIN;
         sat_in    = 1'b1;
      end else begin
         result_in = quo[SAMPLE_W-1:0];
      end
      yh_in[0] = result_in;
      for (int k = 1; k < HIST; k++) yh_in[k] = ye[k-1];
      fbp_in = '0;
      for (int j = 2; j <= HIST; j++) begin
         fbp_opnd[j-2] = ctl.out_load ? ye[j-2] : yh_ff[j-1];
         fbp_prod[j-2] = $signed(coef.fb[j-1]) * fbp_opnd[j-2];
         fbp_in        = fbp_in + ACC_W'(fbp_prod[j-2]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.s1_load) begin
         xh_ff       <= xh_in;
         prod_ff     <= prod;
         s1_tail_ff  <= tail_prod;
         s1_start_ff <= ctl.start;
         s1_fill_ff  <= fill;
      end
      if (ctl.s2_load) begin
         ffsum_ff    <= ffsum_in;
         s2_tail_ff  <= s1_tail_ff;
         s2_start_ff <= s1_start_ff;
         s2_fill_ff  <= s1_fill_ff;
      end
      fbp_ff <= fbp_in;
      if (ctl.out_load) begin
         yh_ff     <= yh_in;
         result_ff <= result_in;
         sat_ff    <= sat_in;
      end
   end

   assign result = result_ff;
   assign sat    = sat_ff;

endmodule

`default_nettype wire

FILE: sv/tlif_csr.sv
// ----------------------------------------------------------------------------
// tlif_csr
// Configuration registers: packed coefficient groups and the priming mode.
// ----------------------------------------------------------------------------
`default_nettype none

module tlif_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tlif_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tlif_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tlif_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output tlif_pkg::tlif_coef_type           coef
);
   import tlif_pkg::*;

   logic [GROUP_W-1:0]        group_ff [GROUPS];
   logic [GROUP_W-1:0]        group_in [GROUPS];
   logic                      prime_ff;
   logic                      prime_in;
   logic                      wr_en;
   tlif_reg_type              idx;
   logic [GROUPS*GROUP_W-1:0] slots;
   logic [TAIL_W-1:0]         tail;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign idx        = tlif_reg_type'(csr_paddr[REG_LSB +: REG_IDX_W]);
   assign csr_pready = 1'b1;

   always_comb begin
      group_in = group_ff;
      prime_in = prime_ff;
      if (wr_en) begin
         unique case (idx)
            REG_COEF_GROUP_0:   group_in[0] = csr_pwdata[GROUP_W-1:0];
            REG_COEF_GROUP_1:   group_in[1] = csr_pwdata[GROUP_W-1:0];
            REG_COEF_GROUP_2:   group_in[2] = csr_pwdata[GROUP_W-1:0];
            REG_PRIME_ON_FIRST: prime_in    = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_COEF_GROUP_0:   csr_prdata = CSR_DATA_W'(group_ff[0]);
         REG_COEF_GROUP_1:   csr_prdata = CSR_DATA_W'(group_ff[1]);
         REG_COEF_GROUP_2:   csr_prdata = CSR_DATA_W'(group_ff[2]);
         REG_PRIME_ON_FIRST: csr_prdata = CSR_DATA_W'(prime_ff);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff <= '{default: '0};
         prime_ff <= 1'b1;
      end else begin
         group_ff <= group_in;
         prime_ff <= prime_in;
      end
   end

   // unpack coefficient slots: feed-forward first, feedback from slot FB_SLOT0+1
   always_comb begin
      for (int g = 0; g < GROUPS; g++) slots[g*GROUP_W +: GROUP_W] = group_ff[g];
      for (int k = 0; k < TAPS; k++) coef.ff[k] = slots[k*COEF_W +: COEF_W];
      for (int j = 1; j <= HIST; j++) begin
         coef.fb[j-1] = slots[(FB_SLOT0 + j)*COEF_W +: COEF_W];
      end
      tail = '0;
      for (int j = 2; j <= HIST; j++) tail = tail + TAIL_W'($signed(coef.fb[j-1]));
      coef.fb_tail = tail;
      coef.prime   = prime_ff;
   end

endmodule

`default_nettype wire

FILE: sv/three_lane_iir_filter.sv
// ----------------------------------------------------------------------------
// three_lane_iir_filter
// Fourth-order direct-form-I IIR filter on three lanes with shared coefficients.
// A request carries one sample per lane (x, y, z) and a restart flag; each
// request yields exactly one response with three filtered samples and a flag
// set when any lane clipped to the 24-bit range.
// Throughput: one request per cycle while responses are not stalled; the closing
// feedback stage (fb1 multiply, add, round, saturate) runs once per cycle and
// sets that rate. A request passes the stage-1, stage-2 and output registers.
// A stalled response holds in the output register while the earlier stages
// keep taking requests until they fill; req_stall rises only then.
// Reset clears the pipeline, zeroes the coefficients and sets prime_on_first;
// the first request after reset, or any request with restart, starts a fresh
// history (filled with its own sample when prime_on_first is set).
// Coefficients are written over the csr_ port, 64-bit registers at 8*index.
// ----------------------------------------------------------------------------
`default_nettype none

module three_lane_iir_filter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  tlif_pkg::tlif_sample_type         req_sample_x,
   input  tlif_pkg::tlif_sample_type         req_sample_y,
   input  tlif_pkg::tlif_sample_type         req_sample_z,
   input  logic                              req_restart,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output tlif_pkg::tlif_sample_type         rsp_out_x,
   output tlif_pkg::tlif_sample_type         rsp_out_y,
   output tlif_pkg::tlif_sample_type         rsp_out_z,
   output logic                              rsp_saturated,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tlif_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tlif_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tlif_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import tlif_pkg::*;

   tlif_coef_type   coef;
   tlif_ctl_type    ctl;
   tlif_sample_type lane_sample [LANES];
   tlif_sample_type lane_result [LANES];
   logic [LANES-1:0] lane_sat;

   logic s1_valid_ff,  s1_valid_in;
   logic s2_valid_ff,  s2_valid_in;
   logic out_valid_ff, out_valid_in;
   logic primed_ff,    primed_in;
   logic out_ready, s2_ready, s1_ready;

   tlif_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   always_comb begin
      out_ready    = !out_valid_ff || !rsp_stall;
      s2_ready     = !s2_valid_ff || out_ready;
      s1_ready     = !s1_valid_ff || s2_ready;
      ctl.s1_load  = req_valid && s1_ready;
      ctl.s2_load  = s1_valid_ff && s2_ready;
      ctl.out_load = s2_valid_ff && out_ready;
      ctl.start    = !primed_ff || req_restart;
      s1_valid_in  = ctl.s1_load || (s1_valid_ff && !ctl.s2_load);
      s2_valid_in  = ctl.s2_load || (s2_valid_ff && !ctl.out_load);
      out_valid_in = ctl.out_load || (out_valid_ff && rsp_stall);
      primed_in    = primed_ff || ctl.s1_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         primed_ff    <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         primed_ff    <= primed_in;
      end
   end

   assign lane_sample[0] = req_sample_x;
   assign lane_sample[1] = req_sample_y;
   assign lane_sample[2] = req_sample_z;

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      tlif_lane u_lane (
         .clock  (clock),
         .ctl    (ctl),
         .coef   (coef),
         .sample (lane_sample[l]),
         .result (lane_result[l]),
         .sat    (lane_sat[l])
      );
   end

   // merge lanes; drive the request stall and response valid
   assign req_stall     = !s1_ready;
   assign rsp_valid     = out_valid_ff;
   assign rsp_out_x     = lane_result[0];
   assign rsp_out_y     = lane_result[1];
   assign rsp_out_z     = lane_result[2];
   assign rsp_saturated = |lane_sat;

endmodule

`default_nettype wire

FILE: sv/tlif_checker.sv
// ----------------------------------------------------------------------------
// tlif_checker
// Port-level checks of the three-lane IIR filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "three_lane_iir_filter_assert.svh"

module tlif_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input tlif_pkg::tlif_sample_type rsp_out_x,
   input tlif_pkg::tlif_sample_type rsp_out_y,
   input tlif_pkg::tlif_sample_type rsp_out_z,
   input logic                      rsp_saturated
);
   import tlif_pkg::*;

   localparam tlif_sample_type S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam tlif_sample_type S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   `TLIF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "response dropped while stalled")

   `TLIF_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_out_x) && $stable(rsp_out_y) && $stable(rsp_out_z) && $stable(rsp_saturated), "stalled response changed")

   `TLIF_ASSERT_SAME(a_no_stall_drained, !rsp_valid || !rsp_stall, !req_stall, "request stalled with free output")

   `TLIF_ASSERT_SAME(a_sat_at_limit, rsp_valid && rsp_saturated, (rsp_out_x == S_MAX) || (rsp_out_x == S_MIN) || (rsp_out_y == S_MAX) || (rsp_out_y == S_MIN) || (rsp_out_z == S_MAX) || (rsp_out_z == S_MIN), "saturation flag without a clipped lane")

endmodule

bind three_lane_iir_filter tlif_checker u_tlif_checker (.*);

`default_nettype wire
